>>> src/daf_pkg.sv
// ----------------------------------------------------------------------------
// daf_pkg
// Shared types and constants for the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package daf_pkg;

    localparam int MAX_CHARS = 16;
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);
    localparam int IDX_W     = $clog2(MAX_CHARS);

    localparam logic [31:0] SIGN_LIMIT  = 32'h7fff_ffff;
    localparam logic [3:0]  MAX_WIDTH   = 4'd10;
    localparam logic [31:0] RECIP_10    = 32'hcccc_cccd;  // 2^35 / 10, rounded up
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;
    localparam logic [7:0]  CHAR_ZERO   = 8'h30;
    localparam logic [7:0]  CHAR_MINUS  = 8'h2d;

    typedef struct packed {
        logic [31:0] value;
        logic        is_signed;
        logic [7:0]  fill_char;
        logic [3:0]  width;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic push_digit;
        logic push_fill;
        logic push_sign;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic quot_zero;
        logic cnt_inc_lt_w;
        logic cnt_inc_eq_w;
        logic fill_nz;
        logic neg;
        logic out_free;
        logic last_char;
    } dp_status_t;

endpackage

>>> src/daf_datapath.sv
// ----------------------------------------------------------------------------
// daf_datapath
// Divide-by-ten unit, character stack and output register.
// ----------------------------------------------------------------------------
module daf_datapath
    import daf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_data,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    logic [31:0]       work_reg, work_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [3:0]        width_reg, width_next;
    logic [7:0]        fill_reg, fill_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic [7:0]        char_mem [MAX_CHARS];

    logic [63:0]       product;
    logic [31:0]       quot_x10;
    logic [31:0]       rem_full;
    logic [7:0]        push_char;
    logic              push_en;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  rd_ptr;
    logic              load_neg;

    assign product   = {32'b0, work_reg} * {32'b0, RECIP_10};
    assign quot_x10  = {quot_reg, 3'b000} + {2'b00, quot_reg, 1'b0};
    assign rem_full  = work_reg - quot_x10;
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign rd_ptr    = count_reg - CNT_W'(1);
    assign load_neg  = s_data.is_signed && (s_data.value > SIGN_LIMIT);
    assign push_en   = (cmd.push_digit || cmd.push_fill || cmd.push_sign)
                       && (count_reg < CNT_W'(MAX_CHARS));

    always_comb begin
        if (cmd.push_digit) begin
            push_char = CHAR_ZERO + {4'b0, rem_full[3:0]};
        end else if (cmd.push_fill) begin
            push_char = fill_reg;
        end else begin
            push_char = CHAR_MINUS;
        end
    end

    always_comb begin
        work_next      = work_reg;
        quot_next      = quot_reg;
        count_next     = count_reg;
        width_next     = width_reg;
        fill_next      = fill_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        if (cmd.load) begin
            work_next  = load_neg ? (~s_data.value + 32'd1) : s_data.value;
            width_next = (s_data.width > MAX_WIDTH) ? MAX_WIDTH : s_data.width;
            fill_next  = s_data.fill_char;
            neg_next   = load_neg;
            count_next = '0;
        end
        if (cmd.mul) begin
            quot_next = product[63:RECIP_SHIFT];
        end
        if (cmd.push_digit) begin
            work_next = {{(32-QUOT_W){1'b0}}, quot_reg};
        end
        if (push_en) begin
            count_next = cnt_inc;
        end
        if (cmd.emit) begin
            out_next.out_char = char_mem[rd_ptr[IDX_W-1:0]];
            out_next.last     = (count_reg == CNT_W'(1));
            out_valid_next    = 1'b1;
            count_next        = rd_ptr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            work_reg      <= work_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        quot_reg  <= quot_next;
        width_reg <= width_next;
        fill_reg  <= fill_next;
        neg_reg   <= neg_next;
        out_reg   <= out_next;
        if (push_en) begin
            char_mem[count_reg[IDX_W-1:0]] <= push_char;
        end
    end

    assign status.quot_zero    = (quot_reg == '0);
    assign status.cnt_inc_lt_w = (cnt_inc < {{(CNT_W-4){1'b0}}, width_reg});
    assign status.cnt_inc_eq_w = (cnt_inc == {{(CNT_W-4){1'b0}}, width_reg});
    assign status.fill_nz      = (fill_reg != 8'h00);
    assign status.neg          = neg_reg;
    assign status.out_free     = !out_valid_reg || m_ready;
    assign status.last_char    = (count_reg == CNT_W'(1));

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> src/daf_controller.sv
// ----------------------------------------------------------------------------
// daf_controller
// Sequencer: divide loop, padding, sign, then character readout.
// ----------------------------------------------------------------------------
module daf_controller
    import daf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        IDLE,
        MUL,
        DIGIT,
        PAD,
        SIGN,
        EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = MUL;
                end
            end
            MUL: begin
                cmd.mul    = 1'b1;
                state_next = DIGIT;
            end
            DIGIT: begin
                cmd.push_digit = 1'b1;
                if (status.quot_zero) begin
                    if (status.cnt_inc_lt_w && status.fill_nz) begin
                        state_next = PAD;
                    end else begin
                        state_next = status.neg ? SIGN : EMIT;
                    end
                end else if (status.cnt_inc_eq_w) begin
                    // width reached, higher digits dropped
                    state_next = status.neg ? SIGN : EMIT;
                end else begin
                    state_next = MUL;
                end
            end
            PAD: begin
                cmd.push_fill = 1'b1;
                if (!status.cnt_inc_lt_w) begin
                    state_next = status.neg ? SIGN : EMIT;
                end
            end
            SIGN: begin
                cmd.push_sign = 1'b1;
                state_next    = EMIT;
            end
            EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.last_char) begin
                        state_next = IDLE;
                    end
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == IDLE);

endmodule

>>> src/decimal_ascii_formatter.sv
// ----------------------------------------------------------------------------
// decimal_ascii_formatter
// Formats a 32-bit value as decimal ASCII, most significant character first.
// ----------------------------------------------------------------------------
// Sequence: after accept, each of D digits takes a multiply-by-reciprocal step
//   (MUL) then a DIGIT step; then P pad characters and, if negative, a minus
//   sign are stacked; readout gives one character per cycle unless m_ready stalls.
// Accept: one number at a time; a new number is taken only when idle.
// Reset: synchronous, active low; returns idle with the output empty.
module decimal_ascii_formatter
    import daf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    daf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    daf_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // one number in flight
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("accepted a new item while busy");

    // returning idle means the last character of the number is on the output
    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(s_ready) |-> m_valid && m_data.last)
        else $error("went idle without presenting the last character");

    // a non-final character means readout is still in progress
    a_busy_mid_number: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> !s_ready)
        else $error("idle while the number is only partly sent");

endmodule
